/* hw/rtl/tcw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // command codes
    localparam logic [2:0] CMD_PUT_CHAR  = 3'd0;
    localparam logic [2:0] CMD_BACKSPACE = 3'd1;
    localparam logic [2:0] CMD_SET_CUR   = 3'd2;
    localparam logic [2:0] CMD_CLEAR     = 3'd3;
    localparam logic [2:0] CMD_READ      = 3'd4;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] CLEAR_CODE   = 8'h00;
    localparam logic [7:0] BLANK_ATTR   = 8'h07;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] char_code;
        logic [4:0] row;
        logic [6:0] col;
    } cmd_t;

    typedef struct packed {
        logic [4:0] cursor_row_now;
        logic [6:0] cursor_col_now;
        logic [7:0] read_char;
        logic [7:0] read_attr;
        logic       scrolled;
    } res_t;

    typedef enum logic [2:0] {
        OP_CHAR,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_SET_CUR,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } op_kind_t;

    // classified command as it travels through the queue
    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] char_code;
        logic [4:0] row;
        logic [6:0] col;
    } op_t;

endpackage : tcw_pkg
`default_nettype wire

/* hw/rtl/text_console_writer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console engine: cursor plus a screen store of character cells,
// driven by put char, backspace, set cursor, clear screen and read commands.
//
// channel   | handshake                  | payload
// ----------+----------------------------+-------------------------------
// command   | start, busy (taken: !busy) | command (tcw_pkg::cmd_t)
// result    | result_valid, one cycle    | result (tcw_pkg::res_t)
// config    | cfg_valid, cfg_ready       | cfg_data (prompt column)
//
// put char, backspace and set cursor finish in the idle state, unless a put
// char scrolls; read goes on through a read state. clear screen and a scroll
// walk the store one cell per cycle through its single write port.
// after reset the store is cleared with busy held high.
// a two-entry command queue takes commands while one executes; busy rises
// when it is full. results are one-cycle strobes and cannot be held off.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
    parameter int SCREEN_ROWS = 25,
    parameter int SCREEN_COLS = 80
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            start,
    output logic           busy,
    input  tcw_pkg::cmd_t  command,
    output logic           result_valid,
    output tcw_pkg::res_t  result,
    input  wire            cfg_valid,
    output logic           cfg_ready,
    input  wire [6:0]      cfg_data
);
    import tcw_pkg::*;

    op_t  push_op, head_op;
    logic push, pop, queue_empty, queue_full, back_init;

    // prompt column transfer is always taken
    assign cfg_ready = 1'b1;

    tcw_front #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .SCREEN_COLS (SCREEN_COLS)
    ) u_front (
        .start      (start),
        .busy       (busy),
        .command    (command),
        .queue_full (queue_full),
        .back_init  (back_init),
        .push       (push),
        .op         (push_op)
    );

    tcw_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .empty   (queue_empty),
        .full    (queue_full)
    );

    tcw_back #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .SCREEN_COLS (SCREEN_COLS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_valid & cfg_ready),
        .cfg_data     (cfg_data),
        .head_op      (head_op),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .back_init    (back_init),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule : text_console_writer_unit
`default_nettype wire

/* hw/rtl/tcw_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : tcw_ram
`default_nettype wire

/* hw/rtl/tcw_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_front
// Command intake: takes a command, clamps its address and classifies it
// before pushing it into the queue.
// ----------------------------------------------------------------------------
module tcw_front #(
    parameter int SCREEN_ROWS = 25,
    parameter int SCREEN_COLS = 80
) (
    input  wire            start,
    output logic           busy,
    input  tcw_pkg::cmd_t  command,
    input  wire            queue_full,
    input  wire            back_init,
    output logic           push,
    output tcw_pkg::op_t   op
);
    import tcw_pkg::*;

    assign busy = queue_full | back_init;
    assign push = start & ~busy;

    always_comb
    begin
        op.char_code = command.char_code;
        op.row       = command.row;
        op.col       = command.col;
        if (int'(command.row) > SCREEN_ROWS - 1)
        begin
            op.row = 5'(SCREEN_ROWS - 1);
        end
        if (int'(command.col) > SCREEN_COLS - 1)
        begin
            op.col = 7'(SCREEN_COLS - 1);
        end

        case (command.cmd)
            CMD_PUT_CHAR:  op.kind = (command.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_CHAR;
            CMD_BACKSPACE: op.kind = OP_BACKSPACE;
            CMD_SET_CUR:   op.kind = OP_SET_CUR;
            CMD_CLEAR:     op.kind = OP_CLEAR;
            CMD_READ:      op.kind = OP_READ;
            default:       op.kind = OP_NOP;
        endcase
    end

endmodule : tcw_front
`default_nettype wire

/* hw/rtl/tcw_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_queue
// Short FIFO of classified commands between intake and execution.
// ----------------------------------------------------------------------------
module tcw_queue (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           push,
    input  tcw_pkg::op_t  push_op,
    input  wire           pop,
    output tcw_pkg::op_t  head_op,
    output logic          empty,
    output logic          full
);
    import tcw_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    op_t                entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head_op = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule : tcw_queue
`default_nettype wire

/* hw/rtl/tcw_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_back
// Command execution: cursor, prompt register, screen store sequencing
// (clear, scroll, read) and the result register.
// ----------------------------------------------------------------------------
module tcw_back #(
    parameter int SCREEN_ROWS = 25,
    parameter int SCREEN_COLS = 80
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            cfg_write,
    input  wire [6:0]      cfg_data,
    input  tcw_pkg::op_t   head_op,
    input  wire            queue_empty,
    output logic           pop,
    output logic           back_init,
    output logic           result_valid,
    output tcw_pkg::res_t  result
);
    import tcw_pkg::*;

    localparam int CELLS     = SCREEN_ROWS * SCREEN_COLS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int ROW_W     = $clog2(SCREEN_ROWS);
    localparam int COL_W     = $clog2(SCREEN_COLS);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLS);
    localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'(CELLS - SCREEN_COLS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_COLS - 1);

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_CLEAR  = 6'b000100,
        ST_SCROLL = 6'b001000,
        ST_FILL   = 6'b010000,
        ST_READ   = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  cnt_reg, cnt_next;
    logic [ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [6:0]         prompt_reg;
    logic               res_valid_reg, res_valid_next;
    res_t               res_reg, res_next;

    logic               we;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [7:0]         wdata, rdata;
    logic               finish, finish_read, finish_scroll;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(ADDR_W'(r) * COLS_A) + ADDR_W'(c);
    endfunction

    // attribute bytes only ever take the blank value, so only characters are stored
    tcw_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_char_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign back_init    = (state_reg == ST_INIT);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        pop           = 1'b0;
        we            = 1'b0;
        waddr         = cnt_reg;
        wdata         = CLEAR_CODE;
        raddr         = cnt_reg;
        finish        = 1'b0;
        finish_read   = 1'b0;
        finish_scroll = 1'b0;

        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                we = 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                    finish     = (state_reg == ST_CLEAR);
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop = 1'b1;
                    case (head_op.kind)
                        OP_CHAR, OP_NEWLINE:
                        begin
                            if (head_op.kind == OP_CHAR)
                            begin
                                we    = 1'b1;
                                waddr = cell_addr(cur_row_reg, cur_col_reg);
                                wdata = head_op.char_code;
                            end
                            if (head_op.kind == OP_NEWLINE || cur_col_reg == LAST_COL)
                            begin
                                cur_col_next = '0;
                                if (cur_row_reg == LAST_ROW)
                                begin
                                    cnt_next   = '0;
                                    state_next = ST_SCROLL;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                    finish       = 1'b1;
                                end
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + 1'b1;
                                finish       = 1'b1;
                            end
                        end
                        OP_BACKSPACE:
                        begin
                            finish = 1'b1;
                            if (7'(cur_col_reg) > prompt_reg)
                            begin
                                cur_col_next = cur_col_reg - 1'b1;
                                we           = 1'b1;
                                waddr        = cell_addr(cur_row_reg, cur_col_reg - 1'b1);
                                wdata        = SPACE_CODE;
                            end
                        end
                        OP_SET_CUR:
                        begin
                            cur_row_next = ROW_W'(head_op.row);
                            cur_col_next = COL_W'(head_op.col);
                            finish       = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        OP_READ:
                        begin
                            raddr      = cell_addr(ROW_W'(head_op.row), COL_W'(head_op.col));
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end

            ST_SCROLL:
            begin
                // read one row ahead, write the cell read in the previous cycle
                if (cnt_reg != LAST_BASE)
                begin
                    raddr = cnt_reg + COLS_A;
                end
                we    = (cnt_reg != '0);
                waddr = cnt_reg - 1'b1;
                wdata = rdata;
                if (cnt_reg == LAST_BASE)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_FILL:
            begin
                we    = 1'b1;
                wdata = SPACE_CODE;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next      = '0;
                    state_next    = ST_IDLE;
                    finish        = 1'b1;
                    finish_scroll = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_READ:
            begin
                finish      = 1'b1;
                finish_read = 1'b1;
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next         = finish;
        res_next.cursor_row_now = 5'(cur_row_next);
        res_next.cursor_col_now = 7'(cur_col_next);
        res_next.read_char      = finish_read ? rdata : 8'h00;
        res_next.read_attr      = finish_read ? BLANK_ATTR : 8'h00;
        res_next.scrolled       = finish_scroll;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            prompt_reg    <= 7'd2;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            res_valid_reg <= res_valid_next;
            if (cfg_write)
            begin
                prompt_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            res_reg <= res_next;
        end
    end

endmodule : tcw_back
`default_nettype wire

/* dv/text_console_writer_checker.sv */
// ----------------------------------------------------------------------------
// text_console_writer_checker
// Watches the command, result and prompt-column channels of the text console
// writer. It keeps its own screen image, cursor and prompt column, predicts
// the result of every accepted command and compares each result strobe with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module text_console_writer_checker #(
    parameter int SCREEN_ROWS = 25,
    parameter int SCREEN_COLS = 80
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            start,
    input  wire            busy,
    input  tcw_pkg::cmd_t  command,
    input  wire            result_valid,
    input  tcw_pkg::res_t  result,
    input  wire            cfg_valid,
    input  wire            cfg_ready,
    input  wire [6:0]      cfg_data,
    output int             fail_count,
    output int             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;

    logic [15:0] screen_image [0:CELLS-1];
    int          caret_row;
    int          caret_col;
    int          prompt_col;
    res_t        console_results_q [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] console result mismatch: %s got %0d, want %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic blank_screen();
        for (int i = 0; i < CELLS; i++)
            screen_image[i] = {BLANK_ATTR, CLEAR_CODE};
    endtask

    // next row, or scroll the whole image up when already on the last row
    task automatic line_feed(output logic scrolled);
        scrolled = 1'b0;
        if (caret_row >= SCREEN_ROWS - 1)
        begin
            for (int i = 0; i + SCREEN_COLS < CELLS; i++)
                screen_image[i] = screen_image[i + SCREEN_COLS];
            for (int i = CELLS - SCREEN_COLS; i < CELLS; i++)
                screen_image[i] = {BLANK_ATTR, SPACE_CODE};
            scrolled = 1'b1;
        end
        else
        begin
            caret_row++;
        end
    endtask

    task automatic step_console(input cmd_t c, output res_t r);
        int   at_row;
        int   at_col;
        int   cell_idx;
        logic scrolled;
        r        = '0;
        scrolled = 1'b0;
        at_row   = (int'(c.row) > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : int'(c.row);
        at_col   = (int'(c.col) > SCREEN_COLS - 1) ? SCREEN_COLS - 1 : int'(c.col);
        case (c.cmd)
            CMD_PUT_CHAR:
            begin
                if (c.char_code == NEWLINE_CODE)
                begin
                    caret_col = 0;
                    line_feed(scrolled);
                end
                else
                begin
                    // only the character byte changes, the attribute stays
                    cell_idx = caret_row * SCREEN_COLS + caret_col;
                    screen_image[cell_idx][7:0] = c.char_code;
                    caret_col++;
                    if (caret_col >= SCREEN_COLS)
                    begin
                        caret_col = 0;
                        line_feed(scrolled);
                    end
                end
            end
            CMD_BACKSPACE:
            begin
                if (caret_col > prompt_col)
                begin
                    caret_col--;
                    cell_idx = caret_row * SCREEN_COLS + caret_col;
                    screen_image[cell_idx][7:0] = SPACE_CODE;
                end
            end
            CMD_SET_CUR:
            begin
                caret_row = at_row;
                caret_col = at_col;
            end
            CMD_CLEAR:
                blank_screen();
            CMD_READ:
            begin
                cell_idx    = at_row * SCREEN_COLS + at_col;
                r.read_char = screen_image[cell_idx][7:0];
                r.read_attr = screen_image[cell_idx][15:8];
            end
            default:
                ;
        endcase
        r.cursor_row_now = 5'(caret_row);
        r.cursor_col_now = 7'(caret_col);
        r.scrolled       = scrolled;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            blank_screen();
            caret_row = 0;
            caret_col = 0;
            prompt_col = 2;
            fail_count = 0;
            console_results_q.delete();
            pending <= 0;
        end
        else
        begin
            // a strobe always belongs to a command taken at an earlier edge
            if (result_valid)
            begin
                got = result;
                if (console_results_q.size() == 0)
                begin
                    report_mismatch("result with no command waiting, row", got.cursor_row_now, -1);
                end
                else
                begin
                    want = console_results_q.pop_front();
                    if (got.cursor_row_now !== want.cursor_row_now)
                        report_mismatch("cursor_row_now", got.cursor_row_now, want.cursor_row_now);
                    if (got.cursor_col_now !== want.cursor_col_now)
                        report_mismatch("cursor_col_now", got.cursor_col_now, want.cursor_col_now);
                    if (got.read_char !== want.read_char)
                        report_mismatch("read_char", got.read_char, want.read_char);
                    if (got.read_attr !== want.read_attr)
                        report_mismatch("read_attr", got.read_attr, want.read_attr);
                    if (got.scrolled !== want.scrolled)
                        report_mismatch("scrolled", got.scrolled, want.scrolled);
                end
            end
            if (cfg_valid && cfg_ready)
                prompt_col = int'(cfg_data);
            if (start && !busy)
            begin
                step_console(command, want);
                console_results_q.push_back(want);
            end
            pending <= console_results_q.size();
        end
    end

endmodule : text_console_writer_checker

/* dv/text_console_writer_unit_test.sv */
// ----------------------------------------------------------------------------
// text_console_writer_unit_test
// Drives the text console writer with a directed set of commands (screen
// corners, wrap and scroll, newline, backspace at the prompt, clear screen,
// unused codes) and then random editing sessions and noise over several
// prompt column settings. Checking is done by the checker beside the block.
// ----------------------------------------------------------------------------
module text_console_writer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int SCREEN_ROWS   = 25;
    localparam int SCREEN_COLS   = 80;
    localparam int CELLS         = SCREEN_ROWS * SCREEN_COLS;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 60;
    localparam int ITEM_BUDGET   = 400;
    localparam int MAX_GAP       = 10;
    localparam int SETTLE_CYCLES = 16;
    // every command a clear or a scroll, every gap at its longest
    localparam int CYCLE_LIMIT   = 4 * (CELLS + ITEM_BUDGET * (2 * CELLS + 2 * MAX_GAP + 8));
    localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
    localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    cmd_t       command;
    logic       result_valid;
    res_t       result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_data;
    int         fail_count;
    int         pending;
    int         items_sent;
    int         no_idle_left;
    int         cycle_count;

    text_console_writer_unit #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .SCREEN_COLS (SCREEN_COLS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    text_console_writer_checker #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .SCREEN_COLS (SCREEN_COLS)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_cmd(input logic [2:0] op, input logic [7:0] ch,
                            input logic [4:0] r, input logic [6:0] c);
        cmd_t item;
        int   gap;
        item.cmd       = op;
        item.char_code = ch;
        item.row       = r;
        item.col       = c;
        if (no_idle_left > 0)
        begin
            gap = 0;
            no_idle_left--;
        end
        else
        begin
            gap = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 12) == 0)
                no_idle_left = $urandom_range(5, 20);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        command <= item;
        do @(posedge clk); while (busy);
        items_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_prompt(input logic [6:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [4:0] pick_row();
        return ($urandom_range(0, 2) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(20, 31));
    endfunction

    function automatic logic [6:0] pick_col();
        return ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 79));
    endfunction

    // place the cursor, type a few characters, rub some out, read them back, maybe end the line
    task automatic edit_session();
        logic [4:0] r;
        logic [6:0] c;
        int         n_chars;
        r       = pick_row();
        c       = pick_col();
        n_chars = $urandom_range(1, 12);
        send_cmd(CMD_SET_CUR, 8'($urandom), r, c);
        repeat (n_chars)
            send_cmd(CMD_PUT_CHAR, 8'($urandom_range(0, 255)), 5'($urandom), 7'($urandom));
        repeat ($urandom_range(0, 4))
            send_cmd(CMD_BACKSPACE, 8'($urandom), 5'($urandom), 7'($urandom));
        repeat ($urandom_range(1, 3))
            send_cmd(CMD_READ, 8'($urandom), r, 7'(c + $urandom_range(0, n_chars)));
        if ($urandom_range(0, 1) == 0)
            send_cmd(CMD_PUT_CHAR, NEWLINE_CODE, 5'($urandom), 7'($urandom));
    endtask

    task automatic noise_item();
        int         pick;
        logic [2:0] op;
        logic [7:0] ch;
        pick = $urandom_range(0, 99);
        ch   = 8'($urandom_range(0, 255));
        if (pick < 35)
            op = CMD_PUT_CHAR;
        else if (pick < 50)
        begin
            op = CMD_PUT_CHAR;
            ch = NEWLINE_CODE;
        end
        else if (pick < 62)
            op = CMD_BACKSPACE;
        else if (pick < 74)
            op = CMD_SET_CUR;
        else if (pick < 90)
            op = CMD_READ;
        else if (pick < 93)
            op = CMD_CLEAR;
        else
            op = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        send_cmd(op, ch, pick_row(), pick_col());
    endtask

    initial
    begin
        int target;
        start        = 1'b0;
        command      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        rst_n        = 1'b0;
        items_sent   = 0;
        no_idle_left = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, prompt column at its reset value
        send_cmd(CMD_READ, 8'h00, 5'd0, 7'd0);
        send_cmd(CMD_PUT_CHAR, 8'h41, 5'd0, 7'd0);
        send_cmd(CMD_PUT_CHAR, 8'hFF, 5'd31, 7'd127);
        send_cmd(CMD_READ, 8'hFF, 5'd0, 7'd1);
        send_cmd(CMD_BACKSPACE, 8'h00, 5'd0, 7'd0);
        send_cmd(CMD_PUT_CHAR, 8'h00, 5'd0, 7'd0);
        send_cmd(CMD_BACKSPACE, 8'h00, 5'd0, 7'd0);
        send_cmd(CMD_READ, 8'h00, 5'd0, 7'd2);
        send_cmd(CMD_READ, 8'h00, 5'd31, 7'd127);
        // wrap at the end of the first row, no scroll
        send_cmd(CMD_SET_CUR, 8'h00, 5'd0, 7'd79);
        send_cmd(CMD_PUT_CHAR, 8'h78, 5'd0, 7'd0);
        send_cmd(CMD_BACKSPACE, 8'h00, 5'd0, 7'd0);
        // wrap in the last cell scrolls the screen
        send_cmd(CMD_SET_CUR, 8'h00, 5'd31, 7'd127);
        send_cmd(CMD_PUT_CHAR, 8'h7A, 5'd0, 7'd0);
        send_cmd(CMD_READ, 8'h00, 5'd23, 7'd79);
        send_cmd(CMD_READ, 8'h00, 5'd24, 7'd0);
        send_cmd(CMD_PUT_CHAR, NEWLINE_CODE, 5'd0, 7'd0);
        send_cmd(CMD_SET_CUR, 8'h00, 5'd3, 7'd10);
        send_cmd(CMD_PUT_CHAR, NEWLINE_CODE, 5'd0, 7'd0);
        send_cmd(CMD_CLEAR, 8'h00, 5'd0, 7'd0);
        send_cmd(CMD_READ, 8'h00, 5'd23, 7'd79);
        send_cmd(CMD_UNUSED_LO, 8'hFF, 5'd31, 7'd127);
        send_cmd(CMD_UNUSED_MID, 8'h00, 5'd0, 7'd0);
        send_cmd(CMD_UNUSED_HI, 8'h55, 5'd10, 7'd40);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       write_prompt(7'd0);
                1:       write_prompt(7'd79);
                2:       write_prompt(7'd127);
                3:       write_prompt(7'($urandom_range(1, 78)));
                default: write_prompt(7'($urandom_range(0, 127)));
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 9) < 7)
                    edit_session();
                else
                    noise_item();
            end
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule : text_console_writer_unit_test
